[hw/rtl/tfn_pkg.sv]
// Package for the triangle face normal unit: shared widths, constants and types.
// No dependencies; every other file uses it.
package tfn_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int NORM_W         = 16;
  localparam int FRAC_BITS      = 14;
  localparam int SCALE_W        = 30;
  localparam int SUM_W          = 2 * SCALE_W + 2;
  localparam int ROOT_W         = SUM_W / 2;
  localparam int QUO_W          = FRAC_BITS + 1;
  localparam logic [NORM_W-1:0] NORM_ONE = NORM_W'(1 << FRAC_BITS);

  typedef logic signed [NORM_W-1:0] norm_t;

  // scaled cross product magnitudes with their signs
  typedef struct packed {
    logic [SCALE_W-1:0] mx;
    logic [SCALE_W-1:0] my;
    logic [SCALE_W-1:0] mz;
    logic [2:0]         neg;
    logic               degen;
  } scaled_t;

  typedef struct packed {
    norm_t nx;
    norm_t ny;
    norm_t nz;
    logic  degen;
  } result_t;

endpackage

[hw/rtl/tfn_chan_if.sv]
// Valid/ready channel interfaces for vertex input beats and normal result beats.
// Depends on tfn_pkg for widths.
interface tfn_in_if #(parameter int COORD_BITS = tfn_pkg::COORD_BITS_DEF);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] first_x;
  logic signed [COORD_BITS-1:0] first_y;
  logic signed [COORD_BITS-1:0] first_z;
  logic signed [COORD_BITS-1:0] second_x;
  logic signed [COORD_BITS-1:0] second_y;
  logic signed [COORD_BITS-1:0] second_z;
  logic signed [COORD_BITS-1:0] third_x;
  logic signed [COORD_BITS-1:0] third_y;
  logic signed [COORD_BITS-1:0] third_z;
  modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  third_x, third_y, third_z, input ready);
  modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                third_x, third_y, third_z, output ready);
endinterface

interface tfn_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [tfn_pkg::NORM_W-1:0]      normal_x;
  logic signed [tfn_pkg::NORM_W-1:0]      normal_y;
  logic signed [tfn_pkg::NORM_W-1:0]      normal_z;
  logic                                   degenerate;
  modport source (output valid, normal_x, normal_y, normal_z, degenerate, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, degenerate, output ready);
endinterface

[hw/rtl/triangle_face_normal_unit.sv]
// Triangle face normal unit: one triangle in, one unit normal out, fully pipelined.
// Depends on tfn_pkg, tfn_chan_if, tfn_cross, tfn_scale, tfn_isqrt and tfn_div.
//
// Takes a triangle every cycle while ready is high and returns its unit face normal
// after 3 stages of edges and cross product, 6 of magnitude, leading-one search,
// scaling and sum of squares, 31 of square root at one bit each, 16 of division
// and rounding at one quotient bit each but the last, and the output register.
// Sustained rate is one triangle per cycle unless stalled; the length is set by
// the bit-per-stage square root and divider. A zero cross product raises degenerate
// with a zero normal. A skid register behind the output register lets the pipe keep
// advancing while one result waits; ready drops only when both are full.
module triangle_face_normal_unit #(
  parameter int COORD_BITS = tfn_pkg::COORD_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  tfn_in_if.sink     in_ch,
  tfn_out_if.source  out_ch
);
  import tfn_pkg::*;

  localparam int RW = (COORD_BITS + 1 > 31) ? 31 : COORD_BITS + 1;
  localparam int CW = 2 * RW + 1;

  // pipeline advances whenever the skid stage is empty
  logic en;

  logic signed [COORD_BITS-1:0] vtx [9];
  assign vtx[0] = in_ch.first_x;
  assign vtx[1] = in_ch.first_y;
  assign vtx[2] = in_ch.first_z;
  assign vtx[3] = in_ch.second_x;
  assign vtx[4] = in_ch.second_y;
  assign vtx[5] = in_ch.second_z;
  assign vtx[6] = in_ch.third_x;
  assign vtx[7] = in_ch.third_y;
  assign vtx[8] = in_ch.third_z;

  logic                 cr_valid;
  logic signed [CW-1:0] cr_c [3];
  logic                 sc_valid;
  scaled_t              sc_data;
  logic [SUM_W-1:0]     sc_sum;
  logic                 rt_valid;
  logic [ROOT_W-1:0]    rt_len;
  scaled_t              rt_data;
  logic                 dv_valid;
  result_t              dv_res;

  tfn_cross #(.CB(COORD_BITS), .CW(CW)) u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid & en),
    .vtx       (vtx),
    .out_valid (cr_valid),
    .c_out     (cr_c)
  );

  tfn_scale #(.CW(CW)) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (cr_valid),
    .c_in      (cr_c),
    .out_valid (sc_valid),
    .sc_out    (sc_data),
    .sum_out   (sc_sum)
  );

  tfn_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sc_valid),
    .s_in      (sc_sum),
    .sc_in     (sc_data),
    .out_valid (rt_valid),
    .root_out  (rt_len),
    .sc_out    (rt_data)
  );

  tfn_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (rt_valid),
    .len_in    (rt_len),
    .sc_in     (rt_data),
    .out_valid (dv_valid),
    .res_out   (dv_res)
  );

  // output register and skid stage
  logic    out_v_r, skid_v_r;
  result_t out_r, skid_r;
  logic    out_v_nxt, skid_v_nxt;
  logic    load_skid_to_out, load_pipe_to_out, load_pipe_to_skid;

  assign en = ~skid_v_r;

  always_comb begin
    load_skid_to_out  = skid_v_r & (~out_v_r | out_ch.ready);
    load_pipe_to_out  = ~skid_v_r & dv_valid & (~out_v_r | out_ch.ready);
    load_pipe_to_skid = ~skid_v_r & dv_valid & out_v_r & ~out_ch.ready;
    out_v_nxt  = out_v_r & ~out_ch.ready;
    skid_v_nxt = skid_v_r;
    if (load_skid_to_out) begin
      out_v_nxt  = 1'b1;
      skid_v_nxt = 1'b0;
    end
    if (load_pipe_to_out) begin
      out_v_nxt = 1'b1;
    end
    if (load_pipe_to_skid) begin
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_skid_to_out) begin
      out_r <= skid_r;
    end else if (load_pipe_to_out) begin
      out_r <= dv_res;
    end
    if (load_pipe_to_skid) begin
      skid_r <= dv_res;
    end
  end

  assign in_ch.ready       = en;
  assign out_ch.valid      = out_v_r;
  assign out_ch.normal_x   = out_r.nx;
  assign out_ch.normal_y   = out_r.ny;
  assign out_ch.normal_z   = out_r.nz;
  assign out_ch.degenerate = out_r.degen;

  // skid fills only behind a held result
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_ch.ready))
    else $error("skid stage filled while output was free");

  // input is held off only when both result registers are occupied
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (skid_v_r && out_v_r))
    else $error("input stalled with room downstream");

  // degenerate results carry a zero normal
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.degen) |-> (out_r.nx == 0 && out_r.ny == 0 && out_r.nz == 0))
    else $error("degenerate result with non-zero normal");

  // components stay within plus or minus one
  assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> (out_r.nx <= 16384 && out_r.nx >= -16384 &&
                 out_r.ny <= 16384 && out_r.ny >= -16384 &&
                 out_r.nz <= 16384 && out_r.nz >= -16384))
    else $error("normal component out of range");

endmodule

[hw/rtl/tfn_cross.sv]
// Edge vectors and cross product, three register stages.
// Depends on tfn_pkg.
module tfn_cross #(
  parameter int CB = tfn_pkg::COORD_BITS_DEF,
  parameter int CW = 2 * ((CB + 1 > 31) ? 31 : CB + 1) + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [CB-1:0] vtx [9],
  output logic                 out_valid,
  output logic signed [CW-1:0] c_out [3]
);
  import tfn_pkg::*;

  localparam int RW = (CB + 1 > 31) ? 31 : CB + 1;
  localparam int SH = (CB + 1 > 31) ? CB - 30 : 0;
  localparam int PW = 2 * RW;

  function automatic logic signed [RW-1:0] reduce(input logic signed [CB:0] d);
    logic [CB:0]          m;
    logic [CB:0]          s;
    logic signed [RW-1:0] r;
    m = d[CB] ? -d : d;
    s = m >> SH;
    r = s[RW-1:0];
    return d[CB] ? -r : r;
  endfunction

  logic signed [RW-1:0] e1_r [3];
  logic signed [RW-1:0] e2_r [3];
  logic signed [PW-1:0] p_r  [6];
  logic signed [CW-1:0] c_r  [3];
  logic [2:0]           v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= reduce({vtx[3+i][CB-1], vtx[3+i]} - {vtx[i][CB-1], vtx[i]});
        e2_r[i] <= reduce({vtx[6+i][CB-1], vtx[6+i]} - {vtx[i][CB-1], vtx[i]});
      end
      p_r[0] <= e1_r[1] * e2_r[2];
      p_r[1] <= e1_r[2] * e2_r[1];
      p_r[2] <= e1_r[2] * e2_r[0];
      p_r[3] <= e1_r[0] * e2_r[2];
      p_r[4] <= e1_r[0] * e2_r[1];
      p_r[5] <= e1_r[1] * e2_r[0];
      for (int i = 0; i < 3; i++) begin
        c_r[i] <= CW'(p_r[2*i]) - CW'(p_r[2*i+1]);
      end
    end
  end

  assign out_valid = v_r[2];
  assign c_out     = c_r;
endmodule

[hw/rtl/tfn_scale.sv]
// Magnitudes, leading-one search, common scaling and sum of squares; six stages.
// Depends on tfn_pkg.
module tfn_scale #(
  parameter int CW = 51
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic signed [CW-1:0]        c_in [3],
  output logic                        out_valid,
  output tfn_pkg::scaled_t            sc_out,
  output logic [tfn_pkg::SUM_W-1:0]   sum_out
);
  import tfn_pkg::*;

  localparam int MW    = CW - 1;
  localparam int NG    = (MW + 7) / 8;
  localparam int PADW  = NG * 8;
  localparam int POS_W = $clog2(PADW);
  localparam int SA_W  = POS_W + 1;
  localparam int WIDE  = MW + SCALE_W;

  logic [5:0]          v_r;
  logic [MW-1:0]       m4_r [3];
  logic [MW-1:0]       m5_r [3];
  logic [MW-1:0]       m6_r [3];
  logic [2:0]          neg4_r, neg5_r, neg6_r;
  logic [PADW-1:0]     or4_r;
  logic [NG-1:0]       any5_r;
  logic [2:0]          idx5_r [NG];
  logic [POS_W-1:0]    pos6_r;
  logic                deg6_r;
  scaled_t             sc7_r, sc8_r, sc9_r;
  logic [2*SCALE_W-1:0] sq8_r [3];
  logic [SUM_W-1:0]    sum9_r;

  logic signed [CW-1:0] cm [3];
  logic [MW-1:0]        mag [3];
  logic [NG-1:0]        any_c;
  logic [2:0]           idx_c [NG];
  logic [POS_W-1:0]     pos_c;
  logic [SA_W-1:0]      sa;
  logic [WIDE-1:0]      wide [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cm[i]  = c_in[i][CW-1] ? -c_in[i] : c_in[i];
      mag[i] = cm[i][MW-1:0];
    end
  end

  // per-byte leading one of the OR of the magnitudes
  always_comb begin
    for (int g = 0; g < NG; g++) begin
      any_c[g] = |or4_r[g*8 +: 8];
      idx_c[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (or4_r[g*8+b]) idx_c[g] = 3'(b);
      end
    end
  end

  always_comb begin
    pos_c = '0;
    for (int g = 0; g < NG; g++) begin
      if (any5_r[g]) pos_c = POS_W'(g * 8) + POS_W'(idx5_r[g]);
    end
  end

  // bring the leading one to bit SCALE_W-1, truncating below
  assign sa = SA_W'(pos6_r) + SA_W'(1);
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wide[i] = {m6_r[i], {SCALE_W{1'b0}}} >> sa;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m4_r[i]   <= mag[i];
        neg4_r[i] <= c_in[i][CW-1];
      end
      or4_r  <= PADW'(mag[0] | mag[1] | mag[2]);
      m5_r   <= m4_r;
      neg5_r <= neg4_r;
      any5_r <= any_c;
      idx5_r <= idx_c;
      m6_r   <= m5_r;
      neg6_r <= neg5_r;
      pos6_r <= pos_c;
      deg6_r <= ~|any5_r;
      sc7_r.mx    <= wide[0][SCALE_W-1:0];
      sc7_r.my    <= wide[1][SCALE_W-1:0];
      sc7_r.mz    <= wide[2][SCALE_W-1:0];
      sc7_r.neg   <= neg6_r;
      sc7_r.degen <= deg6_r;
      sq8_r[0] <= sc7_r.mx * sc7_r.mx;
      sq8_r[1] <= sc7_r.my * sc7_r.my;
      sq8_r[2] <= sc7_r.mz * sc7_r.mz;
      sc8_r    <= sc7_r;
      sum9_r   <= SUM_W'(sq8_r[0]) + SUM_W'(sq8_r[1]) + SUM_W'(sq8_r[2]);
      sc9_r    <= sc8_r;
    end
  end

  assign out_valid = v_r[5];
  assign sc_out    = sc9_r;
  assign sum_out   = sum9_r;
endmodule

[hw/rtl/tfn_isqrt.sv]
// Pipelined integer square root, one result bit per stage.
// Depends on tfn_pkg.
module tfn_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [tfn_pkg::SUM_W-1:0]   s_in,
  input  tfn_pkg::scaled_t            sc_in,
  output logic                        out_valid,
  output logic [tfn_pkg::ROOT_W-1:0]  root_out,
  output tfn_pkg::scaled_t            sc_out
);
  import tfn_pkg::*;

  localparam int REM_W = ROOT_W + 2;

  logic [ROOT_W-1:0] v_r;
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [SUM_W-1:0]  s_r    [ROOT_W];
  scaled_t           sc_r   [ROOT_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[ROOT_W-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic [REM_W-1:0]  rem_i;
    logic [ROOT_W-1:0] root_i;
    logic [SUM_W-1:0]  s_i;
    scaled_t           sc_i;
    logic [REM_W+1:0]  t;
    logic [REM_W+1:0]  trial;
    logic              ge;
    logic [REM_W+1:0]  diff;

    if (k == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign s_i    = s_in;
      assign sc_i   = sc_in;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign s_i    = s_r[k-1];
      assign sc_i   = sc_r[k-1];
    end

    assign t     = {rem_i, s_i[SUM_W-1-2*k -: 2]};
    assign trial = {2'b00, root_i, 2'b01};
    assign ge    = t >= trial;
    assign diff  = t - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[REM_W-1:0] : t[REM_W-1:0];
        root_r[k] <= {root_i[ROOT_W-2:0], ge};
        s_r[k]    <= s_i;
        sc_r[k]   <= sc_i;
      end
    end
  end

  assign out_valid = v_r[ROOT_W-1];
  assign root_out  = root_r[ROOT_W-1];
  assign sc_out    = sc_r[ROOT_W-1];
endmodule

[hw/rtl/tfn_div.sv]
// Pipelined restoring division of each magnitude by the length, then rounding,
// saturation and sign. Depends on tfn_pkg.
module tfn_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [tfn_pkg::ROOT_W-1:0]  len_in,
  input  tfn_pkg::scaled_t            sc_in,
  output logic                        out_valid,
  output tfn_pkg::result_t            res_out
);
  import tfn_pkg::*;

  localparam int T_W = ROOT_W + 1;

  logic [QUO_W:0]     v_r;
  logic [ROOT_W-1:0]  rem_r [QUO_W][3];
  logic [QUO_W-1:0]   q_r   [QUO_W][3];
  logic [ROOT_W-1:0]  len_r [QUO_W];
  logic [2:0]         neg_r [QUO_W];
  logic               deg_r [QUO_W];
  result_t            res_r;

  logic [SCALE_W-1:0] m_in [3];
  assign m_in[0] = sc_in.mx;
  assign m_in[1] = sc_in.my;
  assign m_in[2] = sc_in.mz;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QUO_W-1:0], in_valid};
    end
  end

  for (genvar j = 0; j < QUO_W; j++) begin : g_bit
    logic [ROOT_W-1:0] len_i;
    logic [2:0]        neg_i;
    logic              deg_i;

    if (j == 0) begin : g_first
      assign len_i = len_in;
      assign neg_i = sc_in.neg;
      assign deg_i = sc_in.degen;
    end else begin : g_next
      assign len_i = len_r[j-1];
      assign neg_i = neg_r[j-1];
      assign deg_i = deg_r[j-1];
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [T_W-1:0]   t;
      logic [QUO_W-1:0] q_i;
      logic             ge;
      logic [T_W-1:0]   diff;

      if (j == 0) begin : g_first
        assign t   = T_W'(m_in[l]);
        assign q_i = '0;
      end else begin : g_next
        assign t   = {rem_r[j-1][l], 1'b0};
        assign q_i = q_r[j-1][l];
      end

      assign ge   = t >= {1'b0, len_i};
      assign diff = t - {1'b0, len_i};

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j][l] <= ge ? diff[ROOT_W-1:0] : t[ROOT_W-1:0];
          q_r[j][l]   <= {q_i[QUO_W-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        len_r[j] <= len_i;
        neg_r[j] <= neg_i;
        deg_r[j] <= deg_i;
      end
    end
  end

  // round up once twice the remainder plus one reaches the length (half the
  // length rounded down), clamp to one, apply sign
  norm_t comp [3];
  always_comb begin
    logic [T_W-1:0]    r2;
    logic [NORM_W-1:0] qr;
    logic [NORM_W-1:0] sat;
    for (int l = 0; l < 3; l++) begin
      r2  = {rem_r[QUO_W-1][l], 1'b1};
      qr  = NORM_W'(q_r[QUO_W-1][l]) + NORM_W'(r2 >= {1'b0, len_r[QUO_W-1]});
      sat = (qr > NORM_ONE) ? NORM_ONE : qr;
      if (deg_r[QUO_W-1]) begin
        comp[l] = '0;
      end else if (neg_r[QUO_W-1][l]) begin
        comp[l] = -$signed(sat);
      end else begin
        comp[l] = $signed(sat);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r.nx    <= comp[0];
      res_r.ny    <= comp[1];
      res_r.nz    <= comp[2];
      res_r.degen <= deg_r[QUO_W-1];
    end
  end

  assign out_valid = v_r[QUO_W];
  assign res_out   = res_r;
endmodule
